// ===== hw/rtl/lpr_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Line pixel rasterizer package
// Shared types and screen constants for the line rasterizer.
// ============================================================================
package lpr_pkg;

    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 480;

    localparam int COORD_W  = 10;
    localparam int ERR_W    = 11;
    localparam int COUNT_W  = 11;
    localparam int COLOR_W  = 16;
    localparam int ADDR_W   = 32;
    localparam int OFFSET_W = 21;

    localparam logic [ERR_W-1:0] SCREEN_WIDTH_V  = ERR_W'(SCREEN_WIDTH);
    localparam logic [ERR_W-1:0] SCREEN_HEIGHT_V = ERR_W'(SCREEN_HEIGHT);

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_HOLD = 2'd0,
        DIR_INC  = 2'd1,
        DIR_DEC  = 2'd3
    } dir_t;

    typedef struct packed {
        logic load;
        logic step;
    } axis_ctrl_t;

endpackage

// ===== hw/rtl/line_pixel_rasterizer_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Line pixel rasterizer
// Turns a line between two endpoints into a stream of frame-buffer pixels.
// ============================================================================
// The input channel carries commands. A start command latches both endpoints
// and the color and produces no pixel. Each following step command produces
// one pixel transaction on the output channel with its coordinates, byte
// address, color, an on-screen flag and a last mark. A line of major span D
// gives D + 2 pixels, the first point twice. Steps while no line is active
// are consumed silently, and a start during a line replaces it at once.
// Each input transaction is captured in an input register and is worked off
// from there into the output register, so a pixel reaches the output through
// the input register and then the output register, and one command can be
// accepted every cycle while the receiver does not stall.
// The frame base register is written over its own valid/ready channel, which
// is always ready; it must be written only while the unit is idle.
// When the receiver stalls, the output register holds its pixel and, once the
// input register is also full, the input channel stalls.
// Reset clears the pipeline, ends any active line and sets the base to zero.
// ============================================================================
module line_pixel_rasterizer_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lpr_pkg::ADDR_W-1:0]          frame_base,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic [lpr_pkg::COORD_W-1:0]         x_start,
    input  logic [lpr_pkg::COORD_W-1:0]         y_start,
    input  logic [lpr_pkg::COORD_W-1:0]         x_end,
    input  logic [lpr_pkg::COORD_W-1:0]         y_end,
    input  logic [lpr_pkg::COLOR_W-1:0]         pixel_color,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lpr_pkg::ADDR_W-1:0]          pixel_address,
    output logic [lpr_pkg::COORD_W-1:0]         out_x,
    output logic [lpr_pkg::COORD_W-1:0]         out_y,
    output logic [lpr_pkg::COLOR_W-1:0]         out_color,
    output logic                                written,
    output logic                                last
);

    logic [lpr_pkg::ADDR_W-1:0]   frame_base_reg;

    logic                         in_vld_reg;
    logic                         cmd_reg;
    logic [lpr_pkg::COORD_W-1:0]  x_start_reg;
    logic [lpr_pkg::COORD_W-1:0]  y_start_reg;
    logic [lpr_pkg::COORD_W-1:0]  x_end_reg;
    logic [lpr_pkg::COORD_W-1:0]  y_end_reg;
    logic [lpr_pkg::COLOR_W-1:0]  color_in_reg;

    logic                         active_reg;
    logic                         active_next;
    logic [lpr_pkg::COORD_W-1:0]  major_reg;
    logic [lpr_pkg::COORD_W-1:0]  major_next;
    logic [lpr_pkg::COUNT_W-1:0]  points_reg;
    logic [lpr_pkg::COUNT_W-1:0]  points_next;
    logic [lpr_pkg::COLOR_W-1:0]  held_color_reg;
    logic [lpr_pkg::COLOR_W-1:0]  held_color_next;

    logic                         out_vld_reg;
    logic [lpr_pkg::ADDR_W-1:0]   address_reg;
    logic [lpr_pkg::COORD_W-1:0]  out_x_reg;
    logic [lpr_pkg::COORD_W-1:0]  out_y_reg;
    logic [lpr_pkg::COLOR_W-1:0]  out_color_reg;
    logic                         written_reg;
    logic                         last_reg;

    logic                         in_accept;
    logic                         out_free;
    logic                         process;
    logic                         do_start;
    logic                         do_emit;
    lpr_pkg::axis_ctrl_t          axis_ctrl;
    logic [lpr_pkg::COORD_W-1:0]  span_col;
    logic [lpr_pkg::COORD_W-1:0]  span_row;
    logic [lpr_pkg::COORD_W-1:0]  cur_col;
    logic [lpr_pkg::COORD_W-1:0]  cur_row;
    logic                         on_screen;
    logic                         is_last;
    logic [lpr_pkg::OFFSET_W-1:0] pixel_offset;
    logic [lpr_pkg::ADDR_W-1:0]   address_calc;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_vld_reg || !out_stall;
    assign in_stall  = in_vld_reg && !out_free;
    assign process   = in_vld_reg && out_free;
    assign do_start  = process && (cmd_reg == lpr_pkg::CMD_START);
    assign do_emit   = process && (cmd_reg == lpr_pkg::CMD_STEP) && active_reg;

    assign axis_ctrl.load = do_start;
    assign axis_ctrl.step = do_emit;

    lpr_axis u_axis_col
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (axis_ctrl),
        .from       (x_start_reg),
        .to         (x_end_reg),
        .major_span (major_reg),
        .setup_span (span_col),
        .cur        (cur_col)
    );

    lpr_axis u_axis_row
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (axis_ctrl),
        .from       (y_start_reg),
        .to         (y_end_reg),
        .major_span (major_reg),
        .setup_span (span_row),
        .cur        (cur_row)
    );

    assign on_screen = ({1'b0, cur_col} < lpr_pkg::SCREEN_WIDTH_V) &&
                       ({1'b0, cur_row} < lpr_pkg::SCREEN_HEIGHT_V);
    assign is_last   = (points_reg <= lpr_pkg::COUNT_W'(1));

    assign pixel_offset = lpr_pkg::OFFSET_W'(cur_row) * lpr_pkg::OFFSET_W'(lpr_pkg::SCREEN_WIDTH_V)
                        + lpr_pkg::OFFSET_W'(cur_col);
    assign address_calc = on_screen
                        ? frame_base_reg + {{(lpr_pkg::ADDR_W-lpr_pkg::OFFSET_W-1){1'b0}},
                                            pixel_offset, 1'b0}
                        : '0;

    always_comb
    begin
        active_next     = active_reg;
        major_next      = major_reg;
        points_next     = points_reg;
        held_color_next = held_color_reg;
        if (do_start)
        begin
            major_next      = (span_col > span_row) ? span_col : span_row;
            points_next     = {1'b0, major_next} + lpr_pkg::COUNT_W'(2);
            held_color_next = color_in_reg;
            active_next     = 1'b1;
        end
        else if (do_emit)
        begin
            if (is_last)
            begin
                points_next = '0;
                active_next = 1'b0;
            end
            else
            begin
                points_next = points_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg <= '0;
            in_vld_reg     <= 1'b0;
            active_reg     <= 1'b0;
            major_reg      <= '0;
            points_reg     <= '0;
            held_color_reg <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                frame_base_reg <= frame_base;
            end
            if (in_accept)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (process)
            begin
                in_vld_reg <= 1'b0;
            end
            active_reg     <= active_next;
            major_reg      <= major_next;
            points_reg     <= points_next;
            held_color_reg <= held_color_next;
            if (do_emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg      <= cmd;
            x_start_reg  <= x_start;
            y_start_reg  <= y_start;
            x_end_reg    <= x_end;
            y_end_reg    <= y_end;
            color_in_reg <= pixel_color;
        end
        if (do_emit)
        begin
            address_reg   <= address_calc;
            out_x_reg     <= cur_col;
            out_y_reg     <= cur_row;
            out_color_reg <= held_color_reg;
            written_reg   <= on_screen;
            last_reg      <= is_last;
        end
    end

    assign out_valid     = out_vld_reg;
    assign pixel_address = address_reg;
    assign out_x         = out_x_reg;
    assign out_y         = out_y_reg;
    assign out_color     = out_color_reg;
    assign written       = written_reg;
    assign last          = last_reg;

endmodule

// ===== hw/rtl/lpr_axis.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Line rasterizer axis stepper
// Holds position, error, span and direction of one axis and advances them.
// ============================================================================
module lpr_axis
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  lpr_pkg::axis_ctrl_t                ctrl,
    input  logic [lpr_pkg::COORD_W-1:0]        from,
    input  logic [lpr_pkg::COORD_W-1:0]        to,
    input  logic [lpr_pkg::COORD_W-1:0]        major_span,
    output logic [lpr_pkg::COORD_W-1:0]        setup_span,
    output logic [lpr_pkg::COORD_W-1:0]        cur
);

    logic [lpr_pkg::COORD_W-1:0] cur_reg;
    logic [lpr_pkg::COORD_W-1:0] cur_next;
    logic [lpr_pkg::ERR_W-1:0]   err_reg;
    logic [lpr_pkg::ERR_W-1:0]   err_next;
    logic [lpr_pkg::COORD_W-1:0] span_reg;
    logic [lpr_pkg::COORD_W-1:0] span_next;
    lpr_pkg::dir_t               dir_reg;
    lpr_pkg::dir_t               dir_next;
    lpr_pkg::dir_t               setup_dir;
    logic [lpr_pkg::ERR_W-1:0]   err_sum;

    always_comb
    begin
        if (to > from)
        begin
            setup_span = to - from;
            setup_dir  = lpr_pkg::DIR_INC;
        end
        else if (to < from)
        begin
            setup_span = from - to;
            setup_dir  = lpr_pkg::DIR_DEC;
        end
        else
        begin
            setup_span = '0;
            setup_dir  = lpr_pkg::DIR_HOLD;
        end
    end

    always_comb
    begin
        cur_next  = cur_reg;
        err_next  = err_reg;
        span_next = span_reg;
        dir_next  = dir_reg;
        err_sum   = err_reg + {1'b0, span_reg};
        if (ctrl.load)
        begin
            cur_next  = from;
            err_next  = '0;
            span_next = setup_span;
            dir_next  = setup_dir;
        end
        else if (ctrl.step)
        begin
            err_next = err_sum;
            if (err_sum > {1'b0, major_span})
            begin
                err_next = err_sum - {1'b0, major_span};
                unique case (dir_reg)
                    lpr_pkg::DIR_INC: cur_next = cur_reg + 1'b1;
                    lpr_pkg::DIR_DEC: cur_next = cur_reg - 1'b1;
                    default:          cur_next = cur_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= '0;
            err_reg  <= '0;
            span_reg <= '0;
            dir_reg  <= lpr_pkg::DIR_HOLD;
        end
        else
        begin
            cur_reg  <= cur_next;
            err_reg  <= err_next;
            span_reg <= span_next;
            dir_reg  <= dir_next;
        end
    end

    assign cur = cur_reg;

endmodule

// ===== tb/sv/line_pixel_rasterizer_unit_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Line pixel rasterizer testbench
// Drives line start and step commands with random idling and stalls on both
// channels, across several frame base settings. A scoreboard tracks the line
// stepping and checks each pixel transaction in order against its own
// prediction.
// ============================================================================
typedef struct {
    logic [lpr_pkg::ADDR_W-1:0]  address;
    logic [lpr_pkg::COORD_W-1:0] col;
    logic [lpr_pkg::COORD_W-1:0] row;
    logic [lpr_pkg::COLOR_W-1:0] color;
    logic                        on_screen;
    logic                        final_pixel;
} pixel_t;

class line_raster_scoreboard;
    logic [lpr_pkg::ADDR_W-1:0]  base;
    bit                          active;
    logic [lpr_pkg::COORD_W-1:0] col;
    logic [lpr_pkg::COORD_W-1:0] row;
    logic [lpr_pkg::ERR_W-1:0]   err_col;
    logic [lpr_pkg::ERR_W-1:0]   err_row;
    logic [lpr_pkg::COORD_W-1:0] span_col;
    logic [lpr_pkg::COORD_W-1:0] span_row;
    lpr_pkg::dir_t               dir_col;
    lpr_pkg::dir_t               dir_row;
    logic [lpr_pkg::COORD_W-1:0] major;
    logic [lpr_pkg::COUNT_W-1:0] remaining;
    logic [lpr_pkg::COLOR_W-1:0] line_color;
    pixel_t                      expected_pixels[$];
    int                          errors;
    int                          effective_items;
    int                          lines_started;
    int                          pixels_checked;
    int                          clipped_pixels;
    int                          base_writes;

    function new();
        base = '0;
        active = 1'b0;
        col = '0;
        row = '0;
        err_col = '0;
        err_row = '0;
        span_col = '0;
        span_row = '0;
        dir_col = lpr_pkg::DIR_HOLD;
        dir_row = lpr_pkg::DIR_HOLD;
        major = '0;
        remaining = '0;
        line_color = '0;
        errors = 0;
        effective_items = 0;
        lines_started = 0;
        pixels_checked = 0;
        clipped_pixels = 0;
        base_writes = 0;
    endfunction

    function void set_base(input logic [lpr_pkg::ADDR_W-1:0] value);
        base = value;
        base_writes++;
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction

    function void axis_setup(input logic [lpr_pkg::COORD_W-1:0] from,
                             input logic [lpr_pkg::COORD_W-1:0] to,
                             output logic [lpr_pkg::COORD_W-1:0] span,
                             output lpr_pkg::dir_t dir);
        if (to > from)
        begin
            span = to - from;
            dir = lpr_pkg::DIR_INC;
        end
        else if (to < from)
        begin
            span = from - to;
            dir = lpr_pkg::DIR_DEC;
        end
        else
        begin
            span = '0;
            dir = lpr_pkg::DIR_HOLD;
        end
    endfunction

    function void axis_advance(inout logic [lpr_pkg::COORD_W-1:0] pos,
                               inout logic [lpr_pkg::ERR_W-1:0] err,
                               input logic [lpr_pkg::COORD_W-1:0] span,
                               input lpr_pkg::dir_t dir);
        logic [lpr_pkg::ERR_W-1:0] acc;
        acc = err + lpr_pkg::ERR_W'(span);
        if (acc > lpr_pkg::ERR_W'(major))
        begin
            acc = acc - lpr_pkg::ERR_W'(major);
            if (dir == lpr_pkg::DIR_INC)
                pos = pos + 1'b1;
            else if (dir == lpr_pkg::DIR_DEC)
                pos = pos - 1'b1;
        end
        err = acc;
    endfunction

    function void note_input(input lpr_pkg::cmd_t op,
                             input logic [lpr_pkg::COORD_W-1:0] xs,
                             input logic [lpr_pkg::COORD_W-1:0] ys,
                             input logic [lpr_pkg::COORD_W-1:0] xe,
                             input logic [lpr_pkg::COORD_W-1:0] ye,
                             input logic [lpr_pkg::COLOR_W-1:0] color);
        pixel_t pix;
        if (op == lpr_pkg::CMD_START)
        begin
            axis_setup(xs, xe, span_col, dir_col);
            axis_setup(ys, ye, span_row, dir_row);
            major = (span_col > span_row) ? span_col : span_row;
            col = xs;
            row = ys;
            err_col = '0;
            err_row = '0;
            remaining = lpr_pkg::COUNT_W'(major) + lpr_pkg::COUNT_W'(2);
            line_color = color;
            active = 1'b1;
            lines_started++;
            effective_items++;
        end
        else if (active)
        begin
            pix.on_screen = (col < lpr_pkg::SCREEN_WIDTH) && (row < lpr_pkg::SCREEN_HEIGHT);
            pix.address = pix.on_screen ?
                base + 32'd2 * (32'(col) + 32'(row) * 32'(lpr_pkg::SCREEN_WIDTH)) : '0;
            pix.col = col;
            pix.row = row;
            pix.color = line_color;
            pix.final_pixel = (remaining <= 1);
            expected_pixels.push_back(pix);
            effective_items++;
            axis_advance(col, err_col, span_col, dir_col);
            axis_advance(row, err_row, span_row, dir_row);
            if (pix.final_pixel)
            begin
                remaining = '0;
                active = 1'b0;
            end
            else
                remaining = remaining - 1'b1;
        end
    endfunction

    task report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("pixel %0d %s got 0x%0h, expected 0x%0h",
                                      pixels_checked, name, got, want));
    endtask

    task check_pixel(input logic [lpr_pkg::ADDR_W-1:0] address,
                     input logic [lpr_pkg::COORD_W-1:0] x,
                     input logic [lpr_pkg::COORD_W-1:0] y,
                     input logic [lpr_pkg::COLOR_W-1:0] color,
                     input logic on_screen, input logic final_pixel);
        pixel_t want;
        if (expected_pixels.size() == 0)
            report_mismatch($sformatf("unexpected pixel at (%0d,%0d)", x, y));
        else
        begin
            want = expected_pixels.pop_front();
            compare_field("pixel_address", address, want.address);
            compare_field("out_x", 32'(x), 32'(want.col));
            compare_field("out_y", 32'(y), 32'(want.row));
            compare_field("out_color", 32'(color), 32'(want.color));
            compare_field("written", 32'(on_screen), 32'(want.on_screen));
            compare_field("last", 32'(final_pixel), 32'(want.final_pixel));
            if (!want.on_screen)
                clipped_pixels++;
            pixels_checked++;
        end
    endtask

    task final_check();
        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d expected pixels never arrived",
                                      expected_pixels.size()));
    endtask
endclass

module line_pixel_rasterizer_unit_test;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 8;
    localparam int PHASE_ITEMS  = 85;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [lpr_pkg::ADDR_W-1:0]  frame_base;
    logic                        in_valid;
    logic                        in_stall;
    logic                        cmd;
    logic [lpr_pkg::COORD_W-1:0] x_start;
    logic [lpr_pkg::COORD_W-1:0] y_start;
    logic [lpr_pkg::COORD_W-1:0] x_end;
    logic [lpr_pkg::COORD_W-1:0] y_end;
    logic [lpr_pkg::COLOR_W-1:0] pixel_color;
    logic                        out_valid;
    logic                        out_stall;
    logic [lpr_pkg::ADDR_W-1:0]  pixel_address;
    logic [lpr_pkg::COORD_W-1:0] out_x;
    logic [lpr_pkg::COORD_W-1:0] out_y;
    logic [lpr_pkg::COLOR_W-1:0] out_color;
    logic                        written;
    logic                        last;

    line_raster_scoreboard board;
    bit                    no_idle;
    bit                    hold_req;
    int                    cycle_count;

    line_pixel_rasterizer_unit u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .frame_base    (frame_base),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .x_start       (x_start),
        .y_start       (y_start),
        .x_end         (x_end),
        .y_end         (y_end),
        .pixel_color   (pixel_color),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_address (pixel_address),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_color     (out_color),
        .written       (written),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_item(input lpr_pkg::cmd_t op,
                             input logic [lpr_pkg::COORD_W-1:0] xs,
                             input logic [lpr_pkg::COORD_W-1:0] ys,
                             input logic [lpr_pkg::COORD_W-1:0] xe,
                             input logic [lpr_pkg::COORD_W-1:0] ye,
                             input logic [lpr_pkg::COLOR_W-1:0] color);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd <= op;
        x_start <= xs;
        y_start <= ys;
        x_end <= xe;
        y_end <= ye;
        pixel_color <= color;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        board.note_input(op, xs, ys, xe, ye, color);
    endtask

    task automatic send_step();
        send_item(lpr_pkg::CMD_STEP, lpr_pkg::COORD_W'($urandom), lpr_pkg::COORD_W'($urandom),
                  lpr_pkg::COORD_W'($urandom), lpr_pkg::COORD_W'($urandom),
                  lpr_pkg::COLOR_W'($urandom));
    endtask

    task automatic run_line(input logic [lpr_pkg::COORD_W-1:0] xs,
                            input logic [lpr_pkg::COORD_W-1:0] ys,
                            input logic [lpr_pkg::COORD_W-1:0] xe,
                            input logic [lpr_pkg::COORD_W-1:0] ye,
                            input logic [lpr_pkg::COLOR_W-1:0] color, input int steps);
        send_item(lpr_pkg::CMD_START, xs, ys, xe, ye, color);
        repeat (steps) send_step();
    endtask

    function automatic logic [lpr_pkg::COORD_W-1:0] nearby(input int center, input int reach);
        int v;
        v = center + $urandom_range(0, 2 * reach) - reach;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return lpr_pkg::COORD_W'(v);
    endfunction

    task automatic random_line();
        logic [lpr_pkg::COORD_W-1:0] xs;
        logic [lpr_pkg::COORD_W-1:0] ys;
        logic [lpr_pkg::COORD_W-1:0] xe;
        logic [lpr_pkg::COORD_W-1:0] ye;
        int                          reach;
        int                          span;
        int                          steps;
        int                          kind;
        reach = ($urandom_range(0, 7) == 0) ? 64 : 12;
        if ($urandom_range(0, 3) == 0)
        begin
            xs = nearby(lpr_pkg::SCREEN_WIDTH, 10);
            ys = nearby(lpr_pkg::SCREEN_HEIGHT, 10);
        end
        else
        begin
            xs = lpr_pkg::COORD_W'($urandom);
            ys = lpr_pkg::COORD_W'($urandom);
        end
        xe = nearby(int'(xs), reach);
        ye = nearby(int'(ys), reach);
        span = (xe > xs) ? int'(xe - xs) : int'(xs - xe);
        if (((ye > ys) ? int'(ye - ys) : int'(ys - ye)) > span)
            span = (ye > ys) ? int'(ye - ys) : int'(ys - ye);
        steps = span + 2;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            steps = $urandom_range(1, span + 1);
        else if (kind == 1)
            steps += $urandom_range(1, 3);
        no_idle = ($urandom_range(0, 3) == 0);
        run_line(xs, ys, xe, ye, lpr_pkg::COLOR_W'($urandom), steps);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    task automatic write_base(input logic [lpr_pkg::ADDR_W-1:0] value);
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        frame_base <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_base(value);
    endtask

    initial
    begin : receiver
        int gap;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                gap = no_idle ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    initial
    begin : monitor
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_pixel(pixel_address, out_x, out_y, out_color, written, last);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("line_pixel_rasterizer_unit_test: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        logic [lpr_pkg::ADDR_W-1:0] bases [4];
        int                         goal;
        board = new();
        no_idle = 1'b0;
        hold_req = 1'b0;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        frame_base <= '0;
        in_valid <= 1'b0;
        cmd <= lpr_pkg::CMD_STEP;
        x_start <= '0;
        y_start <= '0;
        x_end <= '0;
        y_end <= '0;
        pixel_color <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed lines at the reset frame base.
        send_step();
        run_line(10'd0, 10'd0, 10'd0, 10'd0, 16'h0000, 3);
        run_line(10'd1023, 10'd1023, 10'd1020, 10'd1021, 16'hFFFF, 5);
        run_line(10'd798, 10'd478, 10'd801, 10'd481, 16'h5A5A, 4);
        run_line(10'd5, 10'd0, 10'd0, 10'd2, 16'hA5A5, 7);

        bases[0] = 32'hFFFF_FFFF;
        bases[1] = $urandom;
        bases[2] = 32'h0000_0000;
        bases[3] = $urandom | 32'h8000_0000;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_base(bases[ph]);
            goal = board.effective_items + PHASE_ITEMS;
            if (ph == 1)
            begin
                // The receiver holds off while a long run of steps keeps coming.
                hold_req = 1'b1;
                no_idle = 1'b1;
                run_line(10'd100, 10'd100, 10'd130, 10'd110, lpr_pkg::COLOR_W'($urandom), 32);
            end
            if (ph == 2)
            begin
                random_line();
                drain();
            end
            while (board.effective_items < goal)
                random_line();
            if (ph == 3)
                run_line(10'd700, 10'd400, 10'd827, 10'd460, lpr_pkg::COLOR_W'($urandom),
                         129);
            while (board.active)
                send_step();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        board.final_check();
        $display("covered %0d lines and %0d pixel transactions, %0d of them clipped,",
                 board.lines_started, board.pixels_checked, board.clipped_pixels);
        $display("over %0d frame base writes in %0d cycles", board.base_writes, cycle_count);
        if (board.errors == 0)
            $display("line_pixel_rasterizer_unit_test: done, clean");
        else
            $display("line_pixel_rasterizer_unit_test: done, errors");
        $finish;
    end

endmodule

// ===== line_pixel_rasterizer_unit.f =====
hw/rtl/lpr_pkg.sv
hw/rtl/lpr_axis.sv
hw/rtl/line_pixel_rasterizer_unit.sv
tb/sv/line_pixel_rasterizer_unit_test.sv
